@@ src/trqs_pkg.sv @@
// ----------------------------------------------------------------------------
// trqs_pkg: shared types for the thread ready-queue scheduler
// Opcodes, status codes, and the structs passed between scheduler blocks.
// ----------------------------------------------------------------------------
package trqs_pkg;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_CREATE  = 3'd1,
		OP_YIELD   = 3'd2,
		OP_BLOCK   = 3'd3,
		OP_FINISH  = 3'd4,
		OP_UNBLOCK = 3'd5
	} trqs_op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ALL_DONE = 3'd1,
		ST_DEADLOCK = 3'd2,
		ST_BAD      = 3'd3,
		ST_NO_SLOT  = 3'd4,
		ST_HALTED   = 3'd5
	} trqs_status_t;

	// ready queue command from the scheduler core
	typedef struct packed {
		logic push;
		logic pop;
	} trqs_fifo_cmd_t;

	// one result transaction
	typedef struct packed {
		logic [2:0] status;
		logic [3:0] thread_id_res;
		logic       run_valid;
	} trqs_result_t;

endpackage

@@ src/trqs_req_if.sv @@
// ----------------------------------------------------------------------------
// trqs_req_if: event request channel
// Valid/ready channel carrying one scheduler event per transaction.
// ----------------------------------------------------------------------------
interface trqs_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [3:0] thread_id;

	modport source (output valid, opcode, thread_id, input ready);
	modport sink   (input valid, opcode, thread_id, output ready);
endinterface

@@ src/trqs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// trqs_rsp_if: scheduler response channel
// Valid/ready channel carrying one result per event.
// ----------------------------------------------------------------------------
interface trqs_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] thread_id_res;
	logic       run_valid;

	modport source  (output valid, status, thread_id_res, run_valid, input ready);
	modport sink    (input valid, status, thread_id_res, run_valid, output ready);
	modport monitor (input valid, ready, status, thread_id_res, run_valid);
endinterface

@@ src/trqs_fifo.sv @@
// ----------------------------------------------------------------------------
// trqs_fifo: ready queue
// Circular queue of slot numbers in a RAM; the read port always holds the
// current head, re-addressed each cycle from the next head pointer.
// ----------------------------------------------------------------------------
module trqs_fifo #(
	parameter int MAX_THREADS = 16,
	parameter int SW = $clog2(MAX_THREADS),
	parameter int CW = $clog2(MAX_THREADS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  trqs_pkg::trqs_fifo_cmd_t cmd,
	input  logic [SW-1:0]            push_data,
	output logic [SW-1:0]            head_data,
	output logic [CW-1:0]            count
);
	import trqs_pkg::*;

	logic [SW-1:0] mem [MAX_THREADS];
	logic [SW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] rd_q;
	logic [SW-1:0] head_inc;
	logic [SW-1:0] raddr;
	logic [SW-1:0] waddr;
	logic [SW:0]   tail_sum;
	logic          we;

	assign we       = cmd.push && (count_q != CW'(MAX_THREADS));
	assign head_inc = (head_q == SW'(MAX_THREADS - 1)) ? '0 : head_q + 1'b1;
	assign raddr    = cmd.pop ? head_inc : head_q;

	// tail = (head + count) mod depth; sum stays below twice the depth
	always_comb begin
		tail_sum = {1'b0, head_q} + (SW + 1)'(count_q);
		if (tail_sum >= (SW + 1)'(MAX_THREADS))
			tail_sum = tail_sum - (SW + 1)'(MAX_THREADS);
		waddr = tail_sum[SW-1:0];
	end

	// write-first read so a push into an empty queue shows up as the head
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= push_data;
		rd_q <= (we && (waddr == raddr)) ? push_data : mem[raddr];
	end

	// a pop on an empty queue consumes the entry pushed in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= raddr;
			count_q <= count_q + CW'(we)
				- CW'(cmd.pop && ((count_q != '0) || we));
		end
	end

	assign head_data = rd_q;
	assign count     = count_q;

endmodule

@@ src/trqs_sched.sv @@
// ----------------------------------------------------------------------------
// trqs_sched: scheduler core
// Slot maps, running thread and halt flag; decodes one event per cycle while
// go is high, and drives the ready queue.
// ----------------------------------------------------------------------------
module trqs_sched #(
	parameter int MAX_THREADS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [2:0]             opcode,
	input  logic [3:0]             thread_id,
	output trqs_pkg::trqs_result_t result
);
	import trqs_pkg::*;

	localparam int SW = $clog2(MAX_THREADS);
	localparam int CW = $clog2(MAX_THREADS + 1);
	localparam int XW = (SW > 4) ? SW : 4;

	logic [MAX_THREADS-1:0] used_q, used_n;
	logic [MAX_THREADS-1:0] blocked_q, blocked_n;
	logic [CW-1:0]          blk_cnt_q, blk_cnt_n;
	logic [SW-1:0]          run_slot_q, run_slot_n;
	logic                   run_v_q, run_v_n;
	logic                   halted_q, halted_n;

	trqs_fifo_cmd_t cmd;
	logic [SW-1:0]  push_data;
	logic [SW-1:0]  head_data;
	logic [CW-1:0]  count;

	logic           free_found;
	logic [SW-1:0]  free_slot;
	logic [XW-1:0]  tid_x;
	logic [SW-1:0]  tid_slot;
	logic           tid_ok;
	logic           do_disp;
	logic           created;
	trqs_status_t   status;
	logic [SW-1:0]  res_slot;
	logic [SW+3:0]  res_wide;

	trqs_fifo #(
		.MAX_THREADS(MAX_THREADS),
		.SW         (SW),
		.CW         (CW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.push_data(push_data),
		.head_data(head_data),
		.count    (count)
	);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = MAX_THREADS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_slot  = SW'(i);
			end
		end
	end

	assign tid_x    = XW'(thread_id);
	assign tid_slot = tid_x[SW-1:0];
	assign tid_ok   = {1'b0, tid_x} < (XW + 1)'(MAX_THREADS);

	always_comb begin
		used_n     = used_q;
		blocked_n  = blocked_q;
		blk_cnt_n  = blk_cnt_q;
		run_slot_n = run_slot_q;
		run_v_n    = run_v_q;
		halted_n   = halted_q;
		cmd        = '0;
		push_data  = '0;
		do_disp    = 1'b0;
		created    = 1'b0;
		status     = ST_BAD;

		if (halted_q) begin
			status = ST_HALTED;
		end else begin
			unique case (trqs_op_t'(opcode))
				OP_START: begin
					if (!run_v_q)
						do_disp = 1'b1;
				end
				OP_CREATE: begin
					if (free_found) begin
						used_n[free_slot]    = 1'b1;
						blocked_n[free_slot] = 1'b0;
						cmd.push             = 1'b1;
						push_data            = free_slot;
						created              = 1'b1;
						status               = ST_OK;
					end else begin
						status = ST_NO_SLOT;
					end
				end
				OP_YIELD: begin
					if (run_v_q) begin
						cmd.push  = 1'b1;
						push_data = run_slot_q;
						do_disp   = 1'b1;
					end
				end
				OP_BLOCK: begin
					if (run_v_q) begin
						blocked_n[run_slot_q] = 1'b1;
						blk_cnt_n             = blk_cnt_q + 1'b1;
						do_disp               = 1'b1;
					end
				end
				OP_FINISH: begin
					if (run_v_q) begin
						used_n[run_slot_q]    = 1'b0;
						blocked_n[run_slot_q] = 1'b0;
						do_disp               = 1'b1;
					end
				end
				OP_UNBLOCK: begin
					if (tid_ok && used_q[tid_slot] && blocked_q[tid_slot]) begin
						blocked_n[tid_slot] = 1'b0;
						blk_cnt_n           = blk_cnt_q - 1'b1;
						cmd.push            = 1'b1;
						push_data           = tid_slot;
						status              = ST_OK;
					end
				end
				default: ;
			endcase

			if (do_disp) begin
				if ((count == '0) && !cmd.push) begin
					halted_n   = 1'b1;
					run_v_n    = 1'b0;
					run_slot_n = '0;
					status     = (blk_cnt_n != '0) ? ST_DEADLOCK : ST_ALL_DONE;
				end else begin
					// yield on an empty queue hands the pushed slot straight back
					cmd.pop    = 1'b1;
					run_slot_n = (count == '0) ? push_data : head_data;
					run_v_n    = 1'b1;
					status     = ST_OK;
				end
			end
		end

		if (!go)
			cmd = '0;
	end

	always_comb begin
		if (halted_q)
			res_slot = '0;
		else if (created)
			res_slot = free_slot;
		else
			res_slot = run_v_n ? run_slot_n : '0;
		res_wide = {4'b0000, res_slot};
	end

	assign result.status        = status;
	assign result.thread_id_res = res_wide[3:0];
	assign result.run_valid     = halted_q ? 1'b0 : run_v_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			blocked_q  <= '0;
			blk_cnt_q  <= '0;
			run_slot_q <= '0;
			run_v_q    <= 1'b0;
			halted_q   <= 1'b0;
		end else if (go) begin
			used_q     <= used_n;
			blocked_q  <= blocked_n;
			blk_cnt_q  <= blk_cnt_n;
			run_slot_q <= run_slot_n;
			run_v_q    <= run_v_n;
			halted_q   <= halted_n;
		end
	end

endmodule

@@ src/thread_ready_queue_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// thread_ready_queue_scheduler_unit: hardware thread scheduler
// Event-driven scheduler over MAX_THREADS slots with a FIFO ready queue.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event per transaction (opcode, thread_id); rsp returns
//   exactly one result per event (status, thread_id_res, run_valid), in order.
//   An event lands in an input register, is decoded from there against the
//   slot maps and the ready queue, and its result sits in an output register.
//   Throughput is one event per cycle while rsp does not stall; the ready
//   queue RAM read port is re-addressed every cycle so the head is always at
//   hand for a dispatch.
//   If rsp stalls, the result holds and one more event waits in the input
//   register; req.ready drops only when both are full.
//   Reset clears all slot maps, the queue pointers, the running thread and
//   the halt flag; queue RAM contents are left as they are. After all-done or
//   deadlock every event answers halted until the next reset.
// ----------------------------------------------------------------------------
module thread_ready_queue_scheduler_unit #(
	parameter int MAX_THREADS = 16
) (
	input logic        clk,
	input logic        arst_n,
	trqs_req_if.sink   req,
	trqs_rsp_if.source rsp
);
	import trqs_pkg::*;

	logic         v_s1;
	logic [2:0]   opcode_s1;
	logic [3:0]   thread_id_s1;
	logic         v_s2;
	trqs_result_t res_s2;
	trqs_result_t result;
	logic         adv;
	logic         go;

	assign adv       = !v_s2 || rsp.ready;
	assign go        = v_s1 && adv;
	assign req.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready)
				v_s1 <= req.valid;
			if (adv)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_s1    <= req.opcode;
			thread_id_s1 <= req.thread_id;
		end
		if (go)
			res_s2 <= result;
	end

	trqs_sched #(
		.MAX_THREADS(MAX_THREADS)
	) u_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.opcode   (opcode_s1),
		.thread_id(thread_id_s1),
		.result   (result)
	);

	assign rsp.valid         = v_s2;
	assign rsp.status        = res_s2.status;
	assign rsp.thread_id_res = res_s2.thread_id_res;
	assign rsp.run_valid     = res_s2.run_valid;

endmodule

@@ src/trqs_chk.sv @@
// ----------------------------------------------------------------------------
// trqs_chk: response channel checker
// Port-level properties of the scheduler response, bound to the top level.
// ----------------------------------------------------------------------------
module trqs_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_status,
	input logic [3:0] rsp_thread_id_res,
	input logic       rsp_run_valid
);
	import trqs_pkg::*;

	// stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_thread_id_res) && $stable(rsp_run_valid))
		else $error("rsp changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("rsp valid during reset");

	// halted answers carry no thread
	a_halted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_HALTED) |->
			!rsp_run_valid && (rsp_thread_id_res == 4'd0))
		else $error("halted response shows a thread");

	// end of schedule shows nothing running and no thread id
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready
			&& ((rsp_status == ST_ALL_DONE) || (rsp_status == ST_DEADLOCK))
			|-> !rsp_run_valid && (rsp_thread_id_res == 4'd0))
		else $error("end status with a running thread");

endmodule

bind thread_ready_queue_scheduler_unit trqs_chk u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_thread_id_res(rsp.thread_id_res),
	.rsp_run_valid    (rsp.run_valid)
);

@@ tb/tb_thread_ready_queue_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// tb_thread_ready_queue_scheduler_unit: scheduler event/response testbench
// Drives scheduler events and checks every response against an in-bench
// scheduler model: bad requests and table fill first, then dispatch basics,
// output backpressure, long random event mixes that stay clear of a halt,
// and a final drain into all-done or deadlock followed by halted traffic.
// ----------------------------------------------------------------------------
module tb_thread_ready_queue_scheduler_unit;
	import trqs_pkg::*;

	localparam int NUM_SLOTS = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	logic clk;
	logic arst_n;

	trqs_req_if req_ch();
	trqs_rsp_if rsp_ch();

	thread_ready_queue_scheduler_unit #(
		.MAX_THREADS(NUM_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// scheduler model state
	logic [3:0]  rq_slots [NUM_SLOTS];
	logic [3:0]  rq_head;
	logic [4:0]  rq_count;
	logic [15:0] blocked_mask;
	logic [15:0] used_mask;
	logic [3:0]  cur_slot;
	bit          cur_valid;
	bit          sched_halted;

	trqs_result_t expected_results [$];
	int err_count;
	int cycle_count;
	int long_stall_cycles;
	bit idle_on;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic trqs_status_t dispatch_next();
		if (rq_count == 0) begin
			cur_valid = 1'b0;
			cur_slot = '0;
			sched_halted = 1'b1;
			return (blocked_mask != '0) ? ST_DEADLOCK : ST_ALL_DONE;
		end
		cur_slot = rq_slots[rq_head];
		rq_head = rq_head + 4'd1;
		rq_count = rq_count - 5'd1;
		cur_valid = 1'b1;
		return ST_OK;
	endfunction

	function automatic void push_ready(logic [3:0] slot);
		logic [3:0] tail;
		tail = rq_head + rq_count[3:0];
		if (rq_count < NUM_SLOTS) begin
			rq_slots[tail] = slot;
			rq_count = rq_count + 5'd1;
		end
	endfunction

	function automatic trqs_result_t predict_event(logic [2:0] op, logic [3:0] tid);
		trqs_result_t r;
		trqs_status_t st;
		logic [3:0] res_id;
		bit have_id;
		if (sched_halted) begin
			r.status = ST_HALTED;
			r.thread_id_res = '0;
			r.run_valid = 1'b0;
			return r;
		end
		st = ST_BAD;
		have_id = 1'b0;
		res_id = '0;
		case (op)
			OP_START: if (!cur_valid) st = dispatch_next();
			OP_CREATE: begin
				st = ST_NO_SLOT;
				for (int i = 0; i < NUM_SLOTS && !have_id; i++) begin
					if (!used_mask[i]) begin
						used_mask[i] = 1'b1;
						blocked_mask[i] = 1'b0;
						push_ready(4'(i));
						st = ST_OK;
						res_id = 4'(i);
						have_id = 1'b1;
					end
				end
			end
			OP_YIELD: if (cur_valid) begin
				push_ready(cur_slot);
				st = dispatch_next();
			end
			OP_BLOCK: if (cur_valid) begin
				blocked_mask[cur_slot] = 1'b1;
				st = dispatch_next();
			end
			OP_FINISH: if (cur_valid) begin
				used_mask[cur_slot] = 1'b0;
				blocked_mask[cur_slot] = 1'b0;
				st = dispatch_next();
			end
			OP_UNBLOCK: if (used_mask[tid] && blocked_mask[tid]) begin
				blocked_mask[tid] = 1'b0;
				push_ready(tid);
				st = ST_OK;
			end
			default: ;
		endcase
		if (!have_id)
			res_id = cur_valid ? cur_slot : 4'd0;
		r.status = st;
		r.thread_id_res = res_id;
		r.run_valid = cur_valid;
		return r;
	endfunction

	task automatic pause_sender(input int n);
		req_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// valid stays high across back-to-back transactions
	task automatic send_event(input logic [2:0] op, input logic [3:0] tid);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.thread_id <= tid;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		expected_results.push_back(predict_event(op, tid));
		if (idle_on && $urandom_range(0, 3) == 0)
			pause_sender($urandom_range(1, 11));
	endtask

	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// random event that keeps the scheduler out of the halted state
	task automatic send_random_event();
		int pick;
		int base;
		bit found;
		logic [2:0] op;
		logic [3:0] tid;
		pick = $urandom_range(0, 99);
		tid = 4'($urandom_range(0, 15));
		found = 1'b0;
		if (pick < 22)
			op = OP_CREATE;
		else if (pick < 42)
			op = OP_YIELD;
		else if (pick < 57)
			op = OP_BLOCK;
		else if (pick < 70)
			op = OP_FINISH;
		else if (pick < 92) begin
			op = OP_UNBLOCK;
			if (blocked_mask != '0 && $urandom_range(0, 5) != 0) begin
				base = $urandom_range(0, NUM_SLOTS - 1);
				for (int k = 0; k < NUM_SLOTS && !found; k++) begin
					if (blocked_mask[(base + k) % NUM_SLOTS]) begin
						tid = 4'((base + k) % NUM_SLOTS);
						found = 1'b1;
					end
				end
			end
		end else begin
			case ($urandom_range(0, 2))
				0: op = OP_START;
				1: op = OP_RSVD6;
				default: op = OP_RSVD7;
			endcase
		end
		// an empty ready queue would halt the scheduler on a switch
		if ((op == OP_BLOCK || op == OP_FINISH) && rq_count == 0)
			op = OP_YIELD;
		if (op == OP_START && !cur_valid && rq_count == 0)
			op = OP_CREATE;
		send_event(op, tid);
	endtask

	task automatic test_idle_bad_requests();
		send_event(OP_YIELD, 4'd9);
		send_event(OP_BLOCK, 4'd6);
		send_event(OP_FINISH, 4'd3);
		send_event(OP_UNBLOCK, 4'd0);
		send_event(OP_RSVD6, 4'd15);
		send_event(OP_RSVD7, 4'd5);
	endtask

	task automatic test_table_fill();
		for (int i = 0; i <= NUM_SLOTS; i++)
			send_event(OP_CREATE, 4'($urandom_range(0, 15)));
		send_event(OP_UNBLOCK, 4'd15);
		send_event(OP_START, 4'd0);
	endtask

	task automatic test_dispatch_basics();
		send_event(OP_START, 4'd7);
		send_event(OP_BLOCK, 4'd0);
		send_event(OP_UNBLOCK, 4'd0);
		send_event(OP_UNBLOCK, 4'd0);
		send_event(OP_FINISH, 4'd12);
		send_event(OP_CREATE, 4'd0);
		send_event(OP_YIELD, 4'd15);
		send_event(OP_UNBLOCK, 4'd10);
	endtask

	// response side stalls long enough for the input side to back up
	task automatic test_backpressure();
		idle_on = 1'b0;
		long_stall_cycles = 60;
		for (int i = 0; i < 24; i++)
			send_random_event();
		wait_all_results();
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic(input int n);
		for (int i = 0; i < n; i++)
			send_random_event();
	endtask

	task automatic test_end_state();
		logic [2:0] all_ops [8];
		all_ops = '{OP_START, OP_CREATE, OP_YIELD, OP_BLOCK, OP_FINISH, OP_UNBLOCK,
			OP_RSVD6, OP_RSVD7};
		if ($urandom_range(0, 1) == 0) begin
			// all-done: release every blocked thread, then finish them all
			while (blocked_mask != '0) begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (blocked_mask[i])
						send_event(OP_UNBLOCK, 4'(i));
			end
			while (!sched_halted)
				send_event(OP_FINISH, 4'($urandom_range(0, 15)));
		end else begin
			while (!sched_halted)
				send_event(OP_BLOCK, 4'($urandom_range(0, 15)));
		end
		for (int i = 0; i < 8; i++)
			send_event(all_ops[i], 4'($urandom_range(0, 15)));
		send_event(OP_UNBLOCK, 4'd15);
		send_event(OP_CREATE, 4'd0);
	endtask

	// response sink
	initial begin
		int n;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_stall_cycles != 0) begin
				n = long_stall_cycles;
				long_stall_cycles = 0;
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		trqs_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected response status=%0d id=%0d run=%0d", $time,
					rsp_ch.status, rsp_ch.thread_id_res, rsp_ch.run_valid);
				err_count++;
			end else begin
				want = expected_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, rsp_ch.status);
					err_count++;
				end
				if (rsp_ch.thread_id_res !== want.thread_id_res) begin
					$display("%0t: thread_id_res expected %0d actual %0d", $time,
						want.thread_id_res, rsp_ch.thread_id_res);
					err_count++;
				end
				if (rsp_ch.run_valid !== want.run_valid) begin
					$display("%0t: run_valid expected %0d actual %0d", $time,
						want.run_valid, rsp_ch.run_valid);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_START;
		req_ch.thread_id <= '0;
		for (int i = 0; i < NUM_SLOTS; i++)
			rq_slots[i] = '0;
		rq_head = '0;
		rq_count = '0;
		blocked_mask = '0;
		used_mask = '0;
		cur_slot = '0;
		cur_valid = 1'b0;
		sched_halted = 1'b0;
		err_count = 0;
		cycle_count = 0;
		long_stall_cycles = 0;
		idle_on = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_bad_requests();
		test_table_fill();
		test_dispatch_basics();
		test_backpressure();
		test_random_traffic(1450);
		idle_on = 1'b0;
		test_random_traffic(300);
		test_end_state();

		wait_all_results();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
